[sv/atapio_pkg.sv]
`timescale 1ns / 1ps

package atapio_pkg;

	localparam int unsigned SIZE_W = 32;
	localparam int unsigned LBA_W = 32;
	localparam int unsigned CHS_LBA_W = 28;
	localparam int unsigned QUOT_W = 23;

	// floor(x / 63) == (x * RECIP_63) >> RECIP_SHIFT for every x below 2^28
	localparam logic [28:0] RECIP_63 = 29'd272696337;
	localparam int unsigned RECIP_SHIFT = 34;

	localparam logic [2:0] REG_PRESENT = 3'd0;
	localparam logic [2:0] REG_CHANNEL = 3'd1;
	localparam logic [2:0] REG_SLAVE = 3'd2;
	localparam logic [2:0] REG_LBA_CAP = 3'd3;
	localparam logic [2:0] REG_SIZE0 = 3'd4;
	localparam logic [2:0] REG_SIZE1 = 3'd5;
	localparam logic [2:0] REG_SIZE2 = 3'd6;
	localparam logic [2:0] REG_SIZE3 = 3'd7;

	localparam logic [2:0] OFS_NONE = 3'd0;
	localparam logic [2:0] OFS_COUNT = 3'd2;
	localparam logic [2:0] OFS_LBA0 = 3'd3;
	localparam logic [2:0] OFS_LBA1 = 3'd4;
	localparam logic [2:0] OFS_LBA2 = 3'd5;
	localparam logic [2:0] OFS_SELECT = 3'd6;
	localparam logic [2:0] OFS_CMD = 3'd7;

	localparam logic [7:0] CTRL_NIEN = 8'h02;
	localparam logic [7:0] CTRL_HOB = 8'h80;
	localparam logic [7:0] SEL_LBA = 8'hE0;
	localparam logic [7:0] SEL_CHS = 8'hA0;

	localparam logic [7:0] CMD_READ = 8'h20;
	localparam logic [7:0] CMD_WRITE = 8'h30;
	localparam logic [7:0] CMD_READ_EXT = 8'h24;
	localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

	typedef enum logic [4:0] {
		ST_DEVCTL,
		ST_SELECT,
		ST_HOB0,
		ST_CNTH,
		ST_NIEN0,
		ST_HOB1,
		ST_LBA3,
		ST_NIEN1,
		ST_HOB2,
		ST_LBA4,
		ST_NIEN2,
		ST_HOB3,
		ST_LBA5,
		ST_NIEN3,
		ST_COUNT,
		ST_LBA0,
		ST_LBA1,
		ST_LBA2,
		ST_CMD
	} step_t;

	typedef struct packed {
		logic       rejected;
		logic       chan;
		logic       lba48;
		logic [7:0] select;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [7:0] cmd;
	} plan_t;

	typedef struct packed {
		logic       rejected;
		logic       channel_sel;
		logic       to_control;
		logic [2:0] reg_offset;
		logic [7:0] write_data;
		logic       last;
	} res_t;

endpackage

[sv/atapio_if.sv]
`timescale 1ns / 1ps

interface atapio_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [2:0]  drive_slot;
	logic [31:0] sector_address;

	modport source (output valid, input ready, output action, output drive_slot,
		output sector_address);
	modport sink (input valid, output ready, input action, input drive_slot,
		input sector_address);
endinterface

interface atapio_res_if;
	logic       valid;
	logic       ready;
	logic       rejected;
	logic       channel_sel;
	logic       to_control;
	logic [2:0] reg_offset;
	logic [7:0] write_data;
	logic       last;

	modport source (output valid, input ready, output rejected, output channel_sel,
		output to_control, output reg_offset, output write_data, output last);
	modport sink (input valid, output ready, input rejected, input channel_sel,
		input to_control, input reg_offset, input write_data, input last);
endinterface

[sv/ata_pio_taskfile_issuer_top.sv]
`timescale 1ns / 1ps

// Task-file setup for single-sector ATA PIO requests. Each request
// (action, drive_slot, sector_address) is checked against the drive
// registers and turned into the ordered register writes: one rejected
// transaction for a bad request, seven for LBA28 or CHS, nineteen for
// LBA48. Results leave one per cycle from the write sequencer while the
// consumer keeps res.ready high. Two decode stages ahead of the sequencer
// take new requests while the current one is still being issued. Drive
// registers are written through the cfg port; the user must write them
// only while no request is in flight, as the block does not enforce this.
module ata_pio_taskfile_issuer_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	atapio_req_if.sink   req,
	atapio_res_if.source res
);

	logic              plan_valid;
	logic              plan_ready;
	atapio_pkg::plan_t plan;

	atapio_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req        (req),
		.plan_valid (plan_valid),
		.plan_ready (plan_ready),
		.plan       (plan)
	);

	atapio_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.plan_valid (plan_valid),
		.plan_ready (plan_ready),
		.plan       (plan),
		.res        (res)
	);

endmodule

[sv/atapio_decode.sv]
`timescale 1ns / 1ps

module atapio_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	atapio_req_if.sink          req,
	output logic                plan_valid,
	input  logic                plan_ready,
	output atapio_pkg::plan_t   plan
);

	logic [3:0] present_q;
	logic [3:0] channel_q;
	logic [3:0] slave_q;
	logic [3:0] lba_cap_q;
	logic [atapio_pkg::SIZE_W-1:0] size_q [4];

	logic                          s1_v_q;
	logic                          action_s1;
	logic [2:0]                    drive_s1;
	logic [atapio_pkg::LBA_W-1:0]  lba_s1;

	logic                          s2_v_q;
	logic                          action_s2;
	logic                          rejected_s2;
	logic                          chan_s2;
	logic                          slave_s2;
	logic                          lba48_s2;
	logic                          lba_cap_s2;
	logic [atapio_pkg::LBA_W-1:0]  lba_s2;
	logic [atapio_pkg::QUOT_W-1:0] quot_s2;

	logic        s1_ready;
	logic        s2_ready;
	logic [1:0]  drv;
	logic        reject;
	logic [56:0] prod;

	logic [atapio_pkg::CHS_LBA_W-1:0] rem_wide;
	logic [7:0]  sector;
	logic [15:0] cyl;
	logic [3:0]  head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			channel_q <= '0;
			slave_q <= '0;
			lba_cap_q <= '0;
			size_q[0] <= '0;
			size_q[1] <= '0;
			size_q[2] <= '0;
			size_q[3] <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				atapio_pkg::REG_PRESENT: present_q <= cfg_data[3:0];
				atapio_pkg::REG_CHANNEL: channel_q <= cfg_data[3:0];
				atapio_pkg::REG_SLAVE: slave_q <= cfg_data[3:0];
				atapio_pkg::REG_LBA_CAP: lba_cap_q <= cfg_data[3:0];
				atapio_pkg::REG_SIZE0, atapio_pkg::REG_SIZE1,
				atapio_pkg::REG_SIZE2, atapio_pkg::REG_SIZE3: begin
					size_q[cfg_index[1:0]] <= cfg_data;
				end
				default: ;
			endcase
		end
	end

	assign s2_ready = !s2_v_q || plan_ready;
	assign s1_ready = !s1_v_q || s2_ready;
	assign req.ready = s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				s1_v_q <= req.valid;
			end
			if (s2_ready) begin
				s2_v_q <= s1_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && req.valid) begin
			action_s1 <= req.action;
			drive_s1 <= req.drive_slot;
			lba_s1 <= req.sector_address;
		end
	end

	assign drv = drive_s1[1:0];
	assign reject = drive_s1[2] || !present_q[drv] || (lba_s1 >= size_q[drv]);
	assign prod = 57'(lba_s1[atapio_pkg::CHS_LBA_W-1:0]) * 57'(atapio_pkg::RECIP_63);

	always_ff @(posedge clk) begin
		if (s2_ready && s1_v_q) begin
			action_s2 <= action_s1;
			rejected_s2 <= reject;
			chan_s2 <= channel_q[drv];
			slave_s2 <= slave_q[drv];
			lba48_s2 <= (lba_s1[31:28] != 4'd0);
			lba_cap_s2 <= lba_cap_q[drv];
			lba_s2 <= lba_s1;
			quot_s2 <= prod[atapio_pkg::RECIP_SHIFT +: atapio_pkg::QUOT_W];
		end
	end

	// CHS: t = 63*q, cylinder = q / 16, head = q mod 16
	assign rem_wide = lba_s2[atapio_pkg::CHS_LBA_W-1:0]
		- (atapio_pkg::CHS_LBA_W'({quot_s2, 6'b0}) - atapio_pkg::CHS_LBA_W'(quot_s2));
	assign sector = 8'(rem_wide[5:0]) + 8'd1;
	assign cyl = quot_s2[19:4];
	assign head = quot_s2[3:0];

	always_comb begin
		plan = '0;
		plan.rejected = rejected_s2;
		if (!rejected_s2) begin
			plan.chan = chan_s2;
			plan.lba48 = lba48_s2;
			if (lba48_s2) begin
				plan.select = atapio_pkg::SEL_LBA | {3'b0, slave_s2, 4'b0};
				plan.b0 = lba_s2[7:0];
				plan.b1 = lba_s2[15:8];
				plan.b2 = lba_s2[23:16];
				plan.b3 = lba_s2[31:24];
				plan.cmd = action_s2 ? atapio_pkg::CMD_WRITE_EXT : atapio_pkg::CMD_READ_EXT;
			end else if (lba_cap_s2) begin
				plan.select = atapio_pkg::SEL_LBA | {3'b0, slave_s2, lba_s2[27:24]};
				plan.b0 = lba_s2[7:0];
				plan.b1 = lba_s2[15:8];
				plan.b2 = lba_s2[23:16];
				plan.cmd = action_s2 ? atapio_pkg::CMD_WRITE : atapio_pkg::CMD_READ;
			end else begin
				plan.select = atapio_pkg::SEL_CHS | {3'b0, slave_s2, head};
				plan.b0 = sector;
				plan.b1 = cyl[7:0];
				plan.b2 = cyl[15:8];
				plan.cmd = action_s2 ? atapio_pkg::CMD_WRITE : atapio_pkg::CMD_READ;
			end
		end
	end

	assign plan_valid = s2_v_q;

endmodule

[sv/atapio_seq.sv]
`timescale 1ns / 1ps

module atapio_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                plan_valid,
	output logic                plan_ready,
	input  atapio_pkg::plan_t   plan,
	atapio_res_if.source        res
);

	atapio_pkg::step_t step_q;
	atapio_pkg::step_t step_nxt;
	atapio_pkg::plan_t plan_q;
	atapio_pkg::res_t  res_q;
	atapio_pkg::res_t  nxt_res;
	logic              plan_v_q;
	logic              res_v_q;
	logic              out_load;
	logic              emit;
	logic              final_step;
	logic              plan_take;

	assign out_load = !res_v_q || res.ready;
	assign emit = plan_v_q && out_load;
	assign final_step = plan_q.rejected || (step_q == atapio_pkg::ST_CMD);
	assign plan_take = !plan_v_q || (emit && final_step);
	assign plan_ready = plan_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= atapio_pkg::ST_DEVCTL;
		end else if (emit) begin
			step_q <= step_nxt;
		end
	end

	always_comb begin
		step_nxt = atapio_pkg::step_t'(step_q + 5'd1);
		nxt_res = '0;
		nxt_res.channel_sel = plan_q.chan;
		nxt_res.reg_offset = atapio_pkg::OFS_NONE;
		case (step_q)
			atapio_pkg::ST_DEVCTL, atapio_pkg::ST_NIEN0, atapio_pkg::ST_NIEN1,
			atapio_pkg::ST_NIEN2, atapio_pkg::ST_NIEN3: begin
				nxt_res.to_control = 1'b1;
				nxt_res.write_data = atapio_pkg::CTRL_NIEN;
			end
			atapio_pkg::ST_HOB0, atapio_pkg::ST_HOB1, atapio_pkg::ST_HOB2,
			atapio_pkg::ST_HOB3: begin
				nxt_res.to_control = 1'b1;
				nxt_res.write_data = atapio_pkg::CTRL_HOB | atapio_pkg::CTRL_NIEN;
			end
			atapio_pkg::ST_SELECT: begin
				nxt_res.reg_offset = atapio_pkg::OFS_SELECT;
				nxt_res.write_data = plan_q.select;
				step_nxt = plan_q.lba48 ? atapio_pkg::ST_HOB0 : atapio_pkg::ST_COUNT;
			end
			atapio_pkg::ST_CNTH: nxt_res.reg_offset = atapio_pkg::OFS_COUNT;
			atapio_pkg::ST_LBA3: begin
				nxt_res.reg_offset = atapio_pkg::OFS_LBA0;
				nxt_res.write_data = plan_q.b3;
			end
			atapio_pkg::ST_LBA4: nxt_res.reg_offset = atapio_pkg::OFS_LBA1;
			atapio_pkg::ST_LBA5: nxt_res.reg_offset = atapio_pkg::OFS_LBA2;
			atapio_pkg::ST_COUNT: begin
				nxt_res.reg_offset = atapio_pkg::OFS_COUNT;
				nxt_res.write_data = 8'd1;
			end
			atapio_pkg::ST_LBA0: begin
				nxt_res.reg_offset = atapio_pkg::OFS_LBA0;
				nxt_res.write_data = plan_q.b0;
			end
			atapio_pkg::ST_LBA1: begin
				nxt_res.reg_offset = atapio_pkg::OFS_LBA1;
				nxt_res.write_data = plan_q.b1;
			end
			atapio_pkg::ST_LBA2: begin
				nxt_res.reg_offset = atapio_pkg::OFS_LBA2;
				nxt_res.write_data = plan_q.b2;
			end
			atapio_pkg::ST_CMD: begin
				nxt_res.reg_offset = atapio_pkg::OFS_CMD;
				nxt_res.write_data = plan_q.cmd;
				nxt_res.last = 1'b1;
			end
			default: ;
		endcase
		if (final_step) begin
			step_nxt = atapio_pkg::ST_DEVCTL;
		end
		if (plan_q.rejected) begin
			nxt_res = '0;
			nxt_res.rejected = 1'b1;
			nxt_res.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plan_v_q <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (plan_take) begin
				plan_v_q <= plan_valid;
			end
			if (out_load) begin
				res_v_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (plan_take && plan_valid) begin
			plan_q <= plan;
		end
		if (emit) begin
			res_q <= nxt_res;
		end
	end

	assign res.valid = res_v_q;
	assign res.rejected = res_q.rejected;
	assign res.channel_sel = res_q.channel_sel;
	assign res.to_control = res_q.to_control;
	assign res.reg_offset = res_q.reg_offset;
	assign res.write_data = res_q.write_data;
	assign res.last = res_q.last;

	a_rej_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_q && res_q.rejected |-> res_q.last && !res_q.to_control)
		else $error("rejected transaction without last");

	a_ctrl_offset: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_q && res_q.to_control |-> res_q.reg_offset == atapio_pkg::OFS_NONE)
		else $error("control write with nonzero offset");

	a_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		emit && nxt_res.last |=> step_q == atapio_pkg::ST_DEVCTL)
		else $error("step not rewound after last transaction");

	a_step_plan: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != atapio_pkg::ST_DEVCTL |-> plan_v_q)
		else $error("sequence in progress without a request");

endmodule

[dv/ata_pio_taskfile_issuer_top_tb.sv]
`timescale 1ns / 1ps

module ata_pio_taskfile_issuer_top_tb;

	typedef struct packed {
		logic        action;
		logic [2:0]  drive;
		logic [31:0] lba;
		logic        refused;
	} req_row_t;

	localparam atapio_pkg::res_t REFUSED = '{rejected: 1'b1, channel_sel: 1'b0,
		to_control: 1'b0, reg_offset: atapio_pkg::OFS_NONE, write_data: 8'h00,
		last: 1'b1};

	localparam int N_DIRECTED = 22;
	localparam req_row_t DIRECTED [N_DIRECTED] = '{
		'{1'b0, 3'd0, 32'h0000_0000, 1'b1},
		'{1'b0, 3'd4, 32'h0000_0000, 1'b1},
		'{1'b1, 3'd7, 32'hFFFF_FFFF, 1'b1},
		'{1'b0, 3'd2, 32'h0000_0000, 1'b1},
		'{1'b0, 3'd0, 32'h0000_0000, 1'b0},
		'{1'b1, 3'd0, 32'h0FFF_FFFF, 1'b0},
		'{1'b0, 3'd0, 32'h1000_0000, 1'b0},
		'{1'b1, 3'd0, 32'hFFFF_FFFE, 1'b0},
		'{1'b1, 3'd0, 32'hFFFF_FFFF, 1'b1},
		'{1'b0, 3'd1, 32'd0, 1'b0},
		'{1'b1, 3'd1, 32'd62, 1'b0},
		'{1'b0, 3'd1, 32'd63, 1'b0},
		'{1'b0, 3'd1, 32'd1007, 1'b0},
		'{1'b1, 3'd1, 32'd1008, 1'b0},
		'{1'b0, 3'd1, 32'h0FFF_FFFF, 1'b0},
		'{1'b0, 3'd1, 32'h1000_0000, 1'b1},
		'{1'b1, 3'd3, 32'd999999, 1'b0},
		'{1'b0, 3'd3, 32'd1000000, 1'b1},
		'{1'b1, 3'd3, 32'd0, 1'b0},
		'{1'b0, 3'd5, 32'h1234_5678, 1'b1},
		'{1'b0, 3'd6, 32'h0000_0000, 1'b1},
		'{1'b1, 3'd4, 32'h0000_0001, 1'b1}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	atapio_req_if req_ch ();
	atapio_res_if res_ch ();

	ata_pio_taskfile_issuer_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.res       (res_ch)
	);

	logic [3:0]  present_m;
	logic [3:0]  channel_m;
	logic [3:0]  slave_m;
	logic [3:0]  lbacap_m;
	logic [31:0] drive_size [4];

	atapio_pkg::res_t pending_writes [$];
	int unsigned      mismatches;
	int unsigned      results_seen;
	bit               steady_send;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#3ms;
		$display("== FAIL ==");
		$finish;
	end

	function automatic atapio_pkg::res_t tf_write(input logic chan, input logic ctrl,
		input logic [2:0] ofs, input logic [7:0] data);
		tf_write = '{rejected: 1'b0, channel_sel: chan, to_control: ctrl,
			reg_offset: ofs, write_data: data, last: 1'b0};
	endfunction

	function automatic void plan_request(input logic act, input logic [2:0] drv,
		input logic [31:0] lba);
		logic             chan;
		logic             slv;
		logic             ext;
		logic [7:0]       sel;
		logic [7:0]       b0;
		logic [7:0]       b1;
		logic [7:0]       b2;
		logic [7:0]       b3;
		logic [7:0]       cmd;
		logic [31:0]      sec;
		logic [31:0]      trk;
		logic [31:0]      cyl;
		logic [31:0]      head;
		atapio_pkg::res_t w;

		if (drv > 3'd3 || !present_m[drv[1:0]] || lba >= drive_size[drv[1:0]]) begin
			pending_writes.push_back(REFUSED);
			return;
		end
		chan = channel_m[drv[1:0]];
		slv = slave_m[drv[1:0]];
		ext = (lba >= 32'h1000_0000);
		b3 = 8'h00;
		if (ext) begin
			b0 = lba[7:0];
			b1 = lba[15:8];
			b2 = lba[23:16];
			b3 = lba[31:24];
			sel = atapio_pkg::SEL_LBA | {3'b000, slv, 4'h0};
		end else if (lbacap_m[drv[1:0]]) begin
			b0 = lba[7:0];
			b1 = lba[15:8];
			b2 = lba[23:16];
			sel = atapio_pkg::SEL_LBA | {3'b000, slv, lba[27:24]};
		end else begin
			sec = lba % 32'd63 + 32'd1;
			trk = lba - (sec - 32'd1);
			cyl = (trk / 32'd1008) & 32'h0000_FFFF;
			head = (trk % 32'd1008) / 32'd63;
			b0 = sec[7:0];
			b1 = cyl[7:0];
			b2 = cyl[15:8];
			sel = atapio_pkg::SEL_CHS | {3'b000, slv, head[3:0]};
		end
		if (act)
			cmd = ext ? atapio_pkg::CMD_WRITE_EXT : atapio_pkg::CMD_WRITE;
		else
			cmd = ext ? atapio_pkg::CMD_READ_EXT : atapio_pkg::CMD_READ;

		pending_writes.push_back(tf_write(chan, 1'b1, atapio_pkg::OFS_NONE,
			atapio_pkg::CTRL_NIEN));
		pending_writes.push_back(tf_write(chan, 1'b0, atapio_pkg::OFS_SELECT, sel));
		if (ext) begin
			for (int i = 0; i < 4; i++) begin
				pending_writes.push_back(tf_write(chan, 1'b1, atapio_pkg::OFS_NONE,
					atapio_pkg::CTRL_HOB | atapio_pkg::CTRL_NIEN));
				pending_writes.push_back(tf_write(chan, 1'b0,
					atapio_pkg::OFS_COUNT + 3'(i), (i == 1) ? b3 : 8'h00));
				pending_writes.push_back(tf_write(chan, 1'b1, atapio_pkg::OFS_NONE,
					atapio_pkg::CTRL_NIEN));
			end
		end
		pending_writes.push_back(tf_write(chan, 1'b0, atapio_pkg::OFS_COUNT, 8'h01));
		pending_writes.push_back(tf_write(chan, 1'b0, atapio_pkg::OFS_LBA0, b0));
		pending_writes.push_back(tf_write(chan, 1'b0, atapio_pkg::OFS_LBA1, b1));
		pending_writes.push_back(tf_write(chan, 1'b0, atapio_pkg::OFS_LBA2, b2));
		w = tf_write(chan, 1'b0, atapio_pkg::OFS_CMD, cmd);
		w.last = 1'b1;
		pending_writes.push_back(w);
	endfunction

	function automatic logic [31:0] pick_size();
		case ($urandom_range(0, 5))
			0: pick_size = 32'd0;
			1: pick_size = 32'd1;
			2: pick_size = $urandom_range(1, 5000);
			3: pick_size = $urandom_range(1, 32'h1000_0000);
			4: pick_size = $urandom;
			default: pick_size = 32'hFFFF_FFFF;
		endcase
	endfunction

	task automatic apply_settings(input logic [3:0] p, input logic [3:0] c,
		input logic [3:0] s, input logic [3:0] l, input logic [31:0] s0,
		input logic [31:0] s1, input logic [31:0] s2, input logic [31:0] s3);
		logic [2:0]  idx [8];
		logic [31:0] val [8];

		idx = '{atapio_pkg::REG_PRESENT, atapio_pkg::REG_CHANNEL, atapio_pkg::REG_SLAVE,
			atapio_pkg::REG_LBA_CAP, atapio_pkg::REG_SIZE0, atapio_pkg::REG_SIZE1,
			atapio_pkg::REG_SIZE2, atapio_pkg::REG_SIZE3};
		val = '{{28'd0, p}, {28'd0, c}, {28'd0, s}, {28'd0, l}, s0, s1, s2, s3};
		present_m = p;
		channel_m = c;
		slave_m = s;
		lbacap_m = l;
		drive_size[0] = s0;
		drive_size[1] = s1;
		drive_size[2] = s2;
		drive_size[3] = s3;
		for (int i = 0; i < 8; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	// drop valid, hold until every pending write has come back
	task automatic settle(input int cycles);
		req_ch.valid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (cycles) @(posedge clk);
	endtask

	task automatic send_req(input logic act, input logic [2:0] drv, input logic [31:0] lba);
		while (!steady_send && $urandom_range(0, 99) < 18) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.drive_slot <= drv;
		req_ch.sector_address <= lba;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	initial begin
		atapio_pkg::res_t got;
		atapio_pkg::res_t want;
		int               hold_left;
		bit               held_once;

		hold_left = 0;
		held_once = 1'b0;
		res_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				got = '{res_ch.rejected, res_ch.channel_sel, res_ch.to_control,
					res_ch.reg_offset, res_ch.write_data, res_ch.last};
				results_seen++;
				if (pending_writes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"unexpected transaction: rej=%0d ch=%0d ctl=%0d",
							" ofs=%0d data=%02h last=%0d"},
							got.rejected, got.channel_sel, got.to_control, got.reg_offset,
							got.write_data, got.last);
				end else begin
					want = pending_writes.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp rej=%0d ch=%0d ctl=%0d ofs=%0d",
								" data=%02h last=%0d",
								" got rej=%0d ch=%0d ctl=%0d ofs=%0d data=%02h last=%0d"},
								want.rejected, want.channel_sel, want.to_control,
								want.reg_offset, want.write_data, want.last, got.rejected,
								got.channel_sel, got.to_control, got.reg_offset,
								got.write_data, got.last);
					end
				end
			end
			if (!held_once && results_seen >= 160) begin
				held_once = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (results_seen >= 500 && results_seen < 900) begin
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= 18);
			end
		end
	end

	initial begin
		logic        act;
		logic [2:0]  drv;
		logic [31:0] lba;
		logic [31:0] sz;
		int unsigned tries;

		mismatches = 0;
		results_seen = 0;
		steady_send = 1'b0;
		present_m = '0;
		channel_m = '0;
		slave_m = '0;
		lbacap_m = '0;
		for (int i = 0; i < 4; i++)
			drive_size[i] = '0;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= atapio_pkg::REG_PRESENT;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.action <= 1'b0;
		req_ch.drive_slot <= '0;
		req_ch.sector_address <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			if (i == 1) begin
				settle(8);
				apply_settings(4'b1011, 4'b1010, 4'b1100, 4'b0101, 32'hFFFF_FFFF,
					32'h1000_0000, 32'h2000_0000, 32'd1000000);
			end
			send_req(DIRECTED[i].action, DIRECTED[i].drive, DIRECTED[i].lba);
			if (DIRECTED[i].refused)
				pending_writes.push_back(REFUSED);
			else
				plan_request(DIRECTED[i].action, DIRECTED[i].drive, DIRECTED[i].lba);
		end

		for (int ph = 0; ph < 6; ph++) begin
			settle(8);
			case (ph)
				0: apply_settings(4'hF, 4'hF, 4'hF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
					32'hFFFF_FFFF, 32'hFFFF_FFFF);
				1: apply_settings(4'hF, 4'h0, 4'h0, 4'h0, $urandom_range(1, 5000),
					$urandom_range(1, 5000), $urandom_range(1, 5000), 32'd1);
				default: apply_settings(4'($urandom), 4'($urandom), 4'($urandom),
					4'($urandom), pick_size(), pick_size(), pick_size(), pick_size());
			endcase
			steady_send = (ph == 2);
			for (int n = 0; n < 25; n++) begin
				act = 1'($urandom);
				if ($urandom_range(0, 99) < 12) begin
					drv = 3'($urandom);
					lba = $urandom;
				end else begin
					drv = 3'($urandom_range(0, 3));
					tries = 0;
					while (!present_m[drv[1:0]] && tries < 8) begin
						drv = 3'($urandom_range(0, 3));
						tries++;
					end
					sz = drive_size[drv[1:0]];
					if (sz == 0) begin
						lba = $urandom;
					end else begin
						case ($urandom_range(0, 3))
							0: lba = $urandom % sz;
							1: lba = sz - 32'd1;
							2: begin
								if (sz > 32'h1000_0000)
									lba = 32'h1000_0000 + $urandom % (sz - 32'h1000_0000);
								else
									lba = $urandom % sz;
							end
							default: lba = $urandom % ((sz < 32'h1000_0000) ? sz : 32'h1000_0000);
						endcase
					end
				end
				send_req(act, drv, lba);
				plan_request(act, drv, lba);
			end
			steady_send = 1'b0;
		end

		settle(20);
		if (mismatches == 0 && pending_writes.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[ata_pio_taskfile_issuer_top.f]
sv/atapio_pkg.sv
sv/atapio_if.sv
sv/atapio_decode.sv
sv/atapio_seq.sv
sv/ata_pio_taskfile_issuer_top.sv
dv/ata_pio_taskfile_issuer_top_tb.sv
